[src/sbr_pkg.sv]
// Shared types and constants of the square block rotator.
// Holds field widths, operation and register codes, and the control/status structs.
// Depends on nothing; the controller, datapath, top level and testbench import it.
package sbr_pkg;

	// Field widths of the stream payloads.
	localparam int VAL_W       = 17;
	localparam int COORD_W     = 9;
	localparam int RAD_W       = 7;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	// Configuration port widths.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Operation codes carried on the input tuser.
	localparam logic OP_ROTATE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Rotation sense.
	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;

	// Register index of the matrix size register (word address bits of paddr).
	localparam logic [PADDR_W-3:0] REG_MATRIX_SIZE = '0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic load_item;
		logic cnt_clr;
		logic cnt_step;
		logic fill_wr;
		logic copy_rd;
		logic put_rd;
		logic item_rd;
		logic load_result;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cfg_wr;
		logic is_read;
		logic err;
		logic last;
		logic out_free;
	} sts_t;

endpackage

[src/square_block_rotator_unit.sv]
// Top level of the square block rotator: joins controller and datapath.
// Depends on sbr_pkg, sbr_ctrl, sbr_datapath (and through it sbr_ram).
//
// Channel   Direction  Handshake         Contents
// s_*       in         tvalid/tready     tuser: op; tdata: row, col, radius, direction
// m_*       out        tvalid/tready     tuser: error; tdata: cell_value
// apb       in/out     psel/penable      register 0: matrix_size
//
// A read word passes the check and done states, then is offered from the output register.
// A rotation sweeps its square twice: the cell and scratch memories each
// give one read per cycle, so each is swept once, one cell per cycle (copy pass,
// then put pass).
// After reset and after every matrix_size write, a refill sweep over all n*n cells
// runs before the first word is accepted; writes to the register are still taken.
// A stalled result holds in the output register; the next word may be accepted
// meanwhile and waits for the register at the end of its work.
module square_block_rotator_unit #(
	parameter int MAX_SIZE = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata, from bit 0: row[8:0], col[17:9], radius[24:18], direction[25], zeros.
	input  logic [sbr_pkg::IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: op.
	input  logic                            s_tuser,
	// Output stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata, from bit 0: cell_value[16:0], zeros.
	output logic [sbr_pkg::OUT_TDATA_W-1:0] m_tdata,
	// m_tuser: error.
	output logic                            m_tuser,
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sbr_pkg::PADDR_W-1:0]     paddr,
	input  logic [sbr_pkg::PDATA_W-1:0]     pwdata,
	output logic [sbr_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);
	import sbr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The register port never waits.
	assign pready   = 1'b1;
	assign s_tready = cmd.in_ready;

	sbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbr_datapath #(
		.MAX_SIZE (MAX_SIZE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata)
	);

endmodule

[src/sbr_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for both the cell store and the scratch store of the rotator.
// Depends on nothing.
module sbr_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/sbr_ctrl.sv]
// Controller state machine of the square block rotator.
// Sequences the refill sweep, item checks, copy and put passes and result hand-over.
// Depends on sbr_pkg.
module sbr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  sbr_pkg::sts_t sts,
	output sbr_pkg::cmd_t cmd
);
	import sbr_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILL  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_GAP   = 3'd4;
	localparam logic [2:0] ST_PUT   = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Next state and command decode.
	always_comb begin
		cmd           = '0;
		state_nxt     = state_q;
		cmd.in_ready  = (state_q == ST_IDLE) && !sts.cfg_wr;
		cmd.load_item = cmd.in_ready && s_tvalid;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load_item) begin
					cmd.cnt_clr = 1'b1;
					state_nxt   = ST_CHECK;
				end
			end
			ST_FILL: begin
				cmd.fill_wr  = 1'b1;
				cmd.cnt_step = 1'b1;
				if (sts.last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (sts.err) begin
					state_nxt = ST_DONE;
				end else if (sts.is_read) begin
					cmd.item_rd = 1'b1;
					state_nxt   = ST_DONE;
				end else begin
					state_nxt = ST_COPY;
				end
			end
			ST_COPY: begin
				cmd.copy_rd  = 1'b1;
				cmd.cnt_step = 1'b1;
				if (sts.last) begin
					cmd.cnt_clr = 1'b1;
					state_nxt   = ST_GAP;
				end
			end
			ST_GAP: begin
				// The last scratch write lands here, before the first scratch read.
				state_nxt = ST_PUT;
			end
			ST_PUT: begin
				cmd.put_rd   = 1'b1;
				cmd.cnt_step = 1'b1;
				if (sts.last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		// A size write restarts the refill sweep from the first cell.
		if (sts.cfg_wr) begin
			cmd.cnt_clr = 1'b1;
			state_nxt   = ST_FILL;
		end
	end

	// State register; reset starts with the refill sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	// An accepted word is always checked in the following cycle.
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> state_q == ST_CHECK)
		else $error("accepted word not followed by check state");

	// A size write always leads into the refill sweep.
	a_cfg_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		sts.cfg_wr |=> state_q == ST_FILL)
		else $error("size write did not start refill");

	// The put pass is entered only through the gap cycle.
	a_put_after_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |-> ($past(state_q) == ST_GAP || $past(state_q) == ST_PUT))
		else $error("put pass entered without gap cycle");

endmodule

[src/sbr_datapath.sv]
// Datapath of the square block rotator: size register, item registers, counters,
// address generation, cell and scratch memories and the result register.
// Depends on sbr_pkg and sbr_ram.
module sbr_datapath #(
	parameter int MAX_SIZE = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbr_pkg::cmd_t                  cmd,
	output sbr_pkg::sts_t                  sts,
	input  logic [sbr_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sbr_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sbr_pkg::PADDR_W-1:0]    paddr,
	input  logic [sbr_pkg::PDATA_W-1:0]    pwdata,
	output logic [sbr_pkg::PDATA_W-1:0]    prdata
);
	import sbr_pkg::*;

	// Index width of one coordinate and width used for bound arithmetic.
	localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CW    = ($clog2(MAX_SIZE + 1) > 10) ? $clog2(MAX_SIZE + 1) : 10;
	localparam int DEPTH = 1 << (2 * IW);

	// Input fields.
	logic [COORD_W-1:0] in_row;
	logic [COORD_W-1:0] in_col;
	logic [RAD_W-1:0]   in_rad;
	logic               in_dir;
	logic [CW-1:0]      row_w;
	logic [CW-1:0]      col_w;
	logic [CW-1:0]      rad_w;
	logic               rot_ok;
	logic               rd_ok;

	// State.
	logic [CW-1:0]    n_q;
	logic             op_q;
	logic             err_q;
	logic             dir_q;
	logic [RAD_W-1:0] rad_q;
	logic [IW-1:0]    base_r_q;
	logic [IW-1:0]    base_c_q;
	logic [IW-1:0]    i_q;
	logic [IW-1:0]    j_q;
	logic [VAL_W-1:0] fill_val_q;
	logic             copy_s1;
	logic             put_s1;
	logic [IW-1:0]    i_s1;
	logic [IW-1:0]    j_s1;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_error_q;

	// Combinational helpers.
	logic [COORD_W-1:0] wr_size;
	logic [COORD_W-1:0] wr_clamp;
	logic [CW-1:0]      lim;
	logic [CW-1:0]      two_r;
	logic               j_end;

	// Memory ports.
	logic                cell_we;
	logic [2*IW-1:0]     cell_waddr;
	logic [VAL_W-1:0]    cell_wdata;
	logic                cell_re;
	logic [2*IW-1:0]     cell_raddr;
	logic [VAL_W-1:0]    cell_rdata;
	logic [2*IW-1:0]     scr_waddr;
	logic [2*IW-1:0]     scr_raddr;
	logic [VAL_W-1:0]    scr_rdata;

	assign in_row = s_tdata[COORD_W-1:0];
	assign in_col = s_tdata[2*COORD_W-1:COORD_W];
	assign in_rad = s_tdata[2*COORD_W+RAD_W-1:2*COORD_W];
	assign in_dir = s_tdata[2*COORD_W+RAD_W];

	// Bound checks of the incoming word against the current size.
	assign row_w  = CW'(in_row);
	assign col_w  = CW'(in_col);
	assign rad_w  = CW'(in_rad);
	assign rot_ok = (row_w > rad_w) && (row_w + rad_w <= n_q)
		&& (col_w > rad_w) && (col_w + rad_w <= n_q);
	assign rd_ok  = (row_w != '0) && (row_w <= n_q) && (col_w != '0) && (col_w <= n_q);

	// Size register write with clamping to one and to the largest size.
	assign sts.cfg_wr = psel && penable && pwrite
		&& (paddr[PADDR_W-1:2] == REG_MATRIX_SIZE);
	assign wr_size    = pwdata[COORD_W-1:0];

	always_comb begin
		wr_clamp = wr_size;
		if (wr_size == '0) begin
			wr_clamp = COORD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CW'(MAX_SIZE);
		end else if (sts.cfg_wr) begin
			if (CW'(wr_clamp) > CW'(MAX_SIZE)) begin
				n_q <= CW'(MAX_SIZE);
			end else begin
				n_q <= CW'(wr_clamp);
			end
		end
	end

	assign prdata = (paddr[PADDR_W-1:2] == REG_MATRIX_SIZE) ? PDATA_W'(n_q) : '0;

	// Item registers; the base is the top-left corner for a rotation, the cell for a read.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= s_tuser;
			dir_q <= in_dir;
			rad_q <= in_rad;
			if (s_tuser == OP_READ) begin
				err_q    <= !rd_ok;
				base_r_q <= IW'(row_w - CW'(1));
				base_c_q <= IW'(col_w - CW'(1));
			end else begin
				err_q    <= !rot_ok;
				base_r_q <= IW'(row_w - rad_w - CW'(1));
				base_c_q <= IW'(col_w - rad_w - CW'(1));
			end
		end
	end

	assign sts.is_read = (op_q == OP_READ);
	assign sts.err     = err_q;

	// Row and column counters over the swept square.
	assign two_r = CW'({rad_q, 1'b0});
	assign lim   = cmd.fill_wr ? (n_q - CW'(1)) : two_r;
	assign j_end = (CW'(j_q) == lim);
	assign sts.last = j_end && (CW'(i_q) == lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			fill_val_q <= VAL_W'(1);
		end else if (cmd.cnt_clr) begin
			i_q        <= '0;
			j_q        <= '0;
			fill_val_q <= VAL_W'(1);
		end else if (cmd.cnt_step) begin
			fill_val_q <= fill_val_q + VAL_W'(1);
			if (j_end) begin
				j_q <= '0;
				i_q <= i_q + IW'(1);
			end else begin
				j_q <= j_q + IW'(1);
			end
		end
	end

	// Memory read stage to write stage: a read issued now is written next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_s1 <= 1'b0;
			put_s1  <= 1'b0;
		end else begin
			copy_s1 <= cmd.copy_rd;
			put_s1  <= cmd.put_rd;
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		j_s1 <= j_q;
	end

	// Cell store addressing.
	assign cell_re    = cmd.copy_rd || cmd.item_rd;
	assign cell_raddr = cmd.item_rd ? {base_r_q, base_c_q}
		: {base_r_q + i_q, base_c_q + j_q};
	assign cell_we    = cmd.fill_wr || put_s1;
	assign cell_waddr = cmd.fill_wr ? {i_q, j_q} : {base_r_q + i_s1, base_c_q + j_s1};
	assign cell_wdata = cmd.fill_wr ? fill_val_q : scr_rdata;

	// Scratch addressing: the put pass reads the source cell of each target cell.
	assign scr_waddr = {i_s1, j_s1};

	always_comb begin
		if (dir_q == DIR_CCW) begin
			scr_raddr = {j_q, IW'(two_r - CW'(i_q))};
		end else begin
			scr_raddr = {IW'(two_r - CW'(j_q)), i_q};
		end
	end

	sbr_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	sbr_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_scratch_ram (
		.clk   (clk),
		.we    (copy_s1),
		.waddr (scr_waddr),
		.wdata (cell_rdata),
		.re    (cmd.put_rd),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	// Output register; it is freed by the consumer taking the word.
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_error_q <= err_q;
			if ((op_q == OP_READ) && !err_q) begin
				out_value_q <= cell_rdata;
			end else begin
				out_value_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_value_q);
	assign m_tuser  = out_error_q;

	// A result never overwrites a word the consumer has not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// Copy-pass and put-pass writes never share a cycle.
	a_pass_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(copy_s1 && put_s1))
		else $error("copy and put passes overlap");

	// An error word always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_error_q) |-> (out_value_q == '0))
		else $error("error word with nonzero value");

endmodule

[sim/tb_square_block_rotator_unit.sv]
// Self-checking testbench for square_block_rotator_unit: streams rotate and read words,
// resizes the matrix over APB, and compares every result word with a tracked copy.
// Depends on sbr_pkg and the RTL of the block; nothing else.
module tb_square_block_rotator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sbr_pkg::*;

	localparam int SIDE_MAX = 256;
	localparam int CYCLE_LIMIT = 4_000_000;
	// Register index with no register behind it.
	localparam logic [PADDR_W-3:0] REG_UNUSED = 1'b1;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             err;
	} cell_result_t;

	// Tracks the matrix contents and the queue of result words still owed by the block.
	class matrix_tracker;
		int unsigned  cells[SIDE_MAX*SIDE_MAX];
		int unsigned  scratch[SIDE_MAX*SIDE_MAX];
		int unsigned  side;
		cell_result_t owed_q[$];
		int           errors;

		function new();
			errors = 0;
			side = SIDE_MAX;
			renumber();
		endfunction

		// Row-major numbering from one inside the active square, zero outside it.
		function void renumber();
			for (int i = 0; i < SIDE_MAX; i++) begin
				for (int j = 0; j < SIDE_MAX; j++) begin
					cells[i*SIDE_MAX+j] = (i < side && j < side) ? i*side + j + 1 : 0;
				end
			end
		endfunction

		// A size of zero counts as one and anything above the maximum saturates.
		function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
			int unsigned v;
			if (addr[PADDR_W-1:2] != REG_MATRIX_SIZE)
				return;
			v = 32'(data[8:0]);
			if (v == 0)
				v = 1;
			if (v > SIDE_MAX)
				v = SIDE_MAX;
			side = v;
			renumber();
		endfunction

		// Copies the square out, then writes it back turned by a quarter.
		function void turn_block(int unsigned r0, int unsigned c0, int unsigned s, logic dir);
			for (int unsigned i = 0; i < s; i++) begin
				for (int unsigned j = 0; j < s; j++) begin
					scratch[i*SIDE_MAX+j] = cells[(r0+i)*SIDE_MAX + c0 + j];
				end
			end
			for (int unsigned i = 0; i < s; i++) begin
				for (int unsigned j = 0; j < s; j++) begin
					if (dir == DIR_CCW)
						cells[(r0+i)*SIDE_MAX + c0 + j] = scratch[j*SIDE_MAX + (s-1-i)];
					else
						cells[(r0+i)*SIDE_MAX + c0 + j] = scratch[(s-1-j)*SIDE_MAX + i];
				end
			end
		endfunction

		// Works out the result of one accepted word and applies it to the matrix.
		function void note_word(logic op, logic [IN_TDATA_W-1:0] data);
			int unsigned  row, col, rad;
			logic         dir;
			cell_result_t res;
			row = 32'(data[8:0]);
			col = 32'(data[17:9]);
			rad = 32'(data[24:18]);
			dir = data[25];
			res.value = '0;
			res.err = 1'b0;
			if (op == OP_READ) begin
				if (row >= 1 && row <= side && col >= 1 && col <= side)
					res.value = VAL_W'(cells[(row-1)*SIDE_MAX + col - 1]);
				else
					res.err = 1'b1;
			end else begin
				if (row > rad && row + rad <= side && col > rad && col + rad <= side)
					turn_block(row - rad - 1, col - rad - 1, 2*rad + 1, dir);
				else
					res.err = 1'b1;
			end
			owed_q.push_back(res);
		endfunction

		function void check_word(logic [OUT_TDATA_W-1:0] data, logic err);
			cell_result_t res;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result word, actual data %h error %b", $time, data, err);
				errors++;
				return;
			end
			res = owed_q.pop_front();
			if (data != OUT_TDATA_W'(res.value)) begin
				$display("%0t: cell_value mismatch, expected %h actual %h",
					$time, res.value, data);
				errors++;
			end
			if (err != res.err) begin
				$display("%0t: error flag mismatch, expected %b actual %b", $time, res.err, err);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	matrix_tracker tracker;
	int            burst_left;
	int            cycles;

	square_block_rotator_unit #(
		.MAX_SIZE(SIDE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("square_block_rotator_unit test failed");
			$finish;
		end
	end

	// Both streams are sampled at the clock edge, before any new drive takes effect.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				tracker.check_word(m_tdata, m_tuser);
		end
	end

	// The receiver switches between randomly chosen stall patterns.
	initial begin
		int mode;
		int left;
		m_tready <= 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((left % 7) < 3);
			endcase
		end
	end

	// Offers one word, opening a new burst after a random gap when the last one ran out.
	task automatic push_word(logic op, logic [8:0] row, logic [8:0] col, logic [6:0] rad,
			logic dir);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, dir, rad, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stops sending and waits until every owed result word has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [PADDR_W-3:0] idx, logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.set_register({idx, 2'b00}, data);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reads the size register back and compares it with the tracked side.
	task automatic check_size_reg();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_MATRIX_SIZE, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata != PDATA_W'(tracker.side)) begin
			$display("%0t: matrix_size readback mismatch, expected %h actual %h",
				$time, tracker.side, prdata);
			tracker.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed rotations and reads on side n, with some noise on every field.
	task automatic random_word(int n);
		int   kind;
		int   rmax;
		logic op;
		logic dir;
		int   row, col, rad;
		kind = $urandom_range(0, 9);
		dir = 1'($urandom_range(0, 1));
		if (kind <= 3) begin
			rmax = (n - 1) / 2;
			if (rmax > 6)
				rmax = 6;
			op = OP_ROTATE;
			rad = $urandom_range(0, rmax);
			row = $urandom_range(rad + 1, n - rad);
			col = $urandom_range(rad + 1, n - rad);
		end else if (kind <= 7) begin
			op = OP_READ;
			rad = $urandom_range(0, 127);
			row = $urandom_range(1, n);
			col = $urandom_range(1, n);
		end else begin
			op = 1'($urandom_range(0, 1));
			rad = $urandom_range(0, 127);
			row = $urandom_range(0, 511);
			col = $urandom_range(0, 511);
			// Keep large turns out of the noise so the run stays short.
			if (op == OP_ROTATE && rad > 8 && row > rad && row + rad <= n &&
					col > rad && col + rad <= n)
				row = rad;
		end
		push_word(op, row[8:0], col[8:0], rad[6:0], dir);
	endtask

	initial begin
		int sizes[7];
		tracker = new();
		burst_left = 0;
		cycles = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-size matrix out of reset: corners, out-of-range cells and the widest turns.
		check_size_reg();
		push_word(OP_READ, 9'd1, 9'd1, 7'd0, DIR_CW);
		push_word(OP_READ, 9'd256, 9'd256, 7'd127, DIR_CCW);
		push_word(OP_READ, 9'd256, 9'd1, 7'd0, DIR_CW);
		push_word(OP_READ, 9'd0, 9'd5, 7'd0, DIR_CW);
		push_word(OP_READ, 9'h1FF, 9'h1FF, 7'h7F, DIR_CCW);
		push_word(OP_ROTATE, 9'd1, 9'd1, 7'd0, DIR_CW);
		push_word(OP_ROTATE, 9'd128, 9'd128, 7'd127, DIR_CW);
		push_word(OP_ROTATE, 9'd127, 9'd128, 7'd127, DIR_CW);
		push_word(OP_ROTATE, 9'd129, 9'd129, 7'd127, DIR_CCW);
		push_word(OP_ROTATE, 9'd10, 9'd10, 7'd3, DIR_CCW);
		push_word(OP_READ, 9'd1, 9'd1, 7'd0, DIR_CW);
		drain();

		// Small matrix: a whole-matrix turn, a smaller turn the other way and squares just over the edge.
		write_reg(REG_MATRIX_SIZE, 32'd5);
		check_size_reg();
		push_word(OP_ROTATE, 9'd3, 9'd3, 7'd2, DIR_CW);
		push_word(OP_READ, 9'd1, 9'd1, 7'd0, DIR_CW);
		push_word(OP_ROTATE, 9'd2, 9'd2, 7'd1, DIR_CCW);
		push_word(OP_READ, 9'd5, 9'd5, 7'd0, DIR_CW);
		push_word(OP_ROTATE, 9'd3, 9'd3, 7'd3, DIR_CW);
		push_word(OP_READ, 9'd6, 9'd1, 7'd0, DIR_CW);
		drain();

		// A size of zero acts as one, also when only the low nine bits are zero.
		write_reg(REG_MATRIX_SIZE, 32'd0);
		check_size_reg();
		push_word(OP_READ, 9'd1, 9'd1, 7'd0, DIR_CW);
		push_word(OP_ROTATE, 9'd1, 9'd1, 7'd0, DIR_CCW);
		push_word(OP_ROTATE, 9'd1, 9'd1, 7'd1, DIR_CW);
		drain();
		write_reg(REG_MATRIX_SIZE, 32'hFFFF_FE00);
		check_size_reg();
		push_word(OP_READ, 9'd1, 9'd2, 7'd0, DIR_CW);
		drain();

		// Oversized write saturates; a write to an unused index changes nothing.
		write_reg(REG_MATRIX_SIZE, 32'd300);
		check_size_reg();
		push_word(OP_READ, 9'd256, 9'd256, 7'd0, DIR_CW);
		drain();
		write_reg(REG_UNUSED, 32'd3);
		check_size_reg();
		push_word(OP_READ, 9'd200, 9'd17, 7'd0, DIR_CW);
		drain();

		// Random words over a spread of matrix sizes.
		sizes = '{2, 9, 1, 16, 256, 5, 32};
		foreach (sizes[p]) begin
			write_reg(REG_MATRIX_SIZE, PDATA_W'(sizes[p]));
			for (int k = 0; k < 11; k++)
				random_word(sizes[p]);
			drain();
		end

		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("square_block_rotator_unit test passed");
		end else begin
			$display("square_block_rotator_unit test failed");
		end
		$finish;
	end

endmodule

[square_block_rotator_unit.f]
src/sbr_pkg.sv
src/sbr_ram.sv
src/sbr_ctrl.sv
src/sbr_datapath.sv
src/square_block_rotator_unit.sv
sim/tb_square_block_rotator_unit.sv
